>>> hw/rtl/rrb_pkg.sv
// Shared types and constants for the request/retry bridge.
`timescale 1ns / 1ps

package rrb_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_REPLY   = 2'd2
  } action_t;

  typedef enum logic {
    KIND_BUS_REQ   = 1'b0,
    KIND_CAN_REPLY = 1'b1
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_STATUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 2'd3;

  localparam logic [BYTE_W-1:0]  RST_FLAG_MASK   = 8'h80;
  localparam logic [BYTE_W-1:0]  RST_DISC_STATUS = 8'h00;
  localparam logic [BYTE_W-1:0]  RST_TIMEOUT     = 8'd2;
  localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 4'd3;

endpackage

>>> hw/rtl/request_retry_bridge.sv
// Request/retry bridge between a CAN-side master and a serial-bus board.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid/in_ready   | action, command, board, status, data, station
// out_     | output    | out_valid/out_ready | kind, command, board, status, data, station
// cfg_     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One transaction a cycle while in_ready is high: each input is decoded, the state updated
// at acceptance; any result is registered at that same edge, on out_ from the next cycle.
// in_ready is high whenever the output register is empty or being drained this cycle.
// rst_n is synchronous, active low: idle, counters cleared, config registers at reset values.
// A stalled result holds the output register and the input side until it is taken.

module request_retry_bridge (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_cmd_code,
  input  logic [7:0] in_board_type,
  input  logic [7:0] in_board_id,
  input  logic [7:0] in_status_byte,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_station,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_cmd,
  output logic [7:0] out_type,
  output logic [7:0] out_id,
  output logic [7:0] out_status,
  output logic [7:0] out_data,
  output logic [7:0] out_station,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration
  logic [7:0] flag_mask_r, disc_status_r, timeout_r;
  logic [3:0] max_retries_r;

  // transaction state
  logic       busy_r, busy_nxt;
  logic [7:0] held_cmd_r, held_cmd_nxt;
  logic [7:0] held_type_r, held_type_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_status_r, held_status_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic [7:0] held_station_r, held_station_nxt;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic [3:0] retry_count_r, retry_count_nxt;

  // output register
  logic       out_valid_r;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_cmd_r, out_cmd_nxt;
  logic [7:0] out_type_r, out_id_r, out_station_r;
  logic [7:0] out_status_r, out_status_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  logic in_fire;
  logic emit;
  logic retry_due;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_mask_r   <= rrb_pkg::RST_FLAG_MASK;
      disc_status_r <= rrb_pkg::RST_DISC_STATUS;
      timeout_r     <= rrb_pkg::RST_TIMEOUT;
      max_retries_r <= rrb_pkg::RST_MAX_RETRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        rrb_pkg::REG_FLAG_MASK:   flag_mask_r   <= cfg_data;
        rrb_pkg::REG_DISC_STATUS: disc_status_r <= cfg_data;
        rrb_pkg::REG_TIMEOUT:     timeout_r     <= cfg_data;
        rrb_pkg::REG_MAX_RETRIES: max_retries_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt         = busy_r;
    held_cmd_nxt     = held_cmd_r;
    held_type_nxt    = held_type_r;
    held_id_nxt      = held_id_r;
    held_status_nxt  = held_status_r;
    held_data_nxt    = held_data_r;
    held_station_nxt = held_station_r;
    tick_count_nxt   = tick_count_r;
    retry_count_nxt  = retry_count_r;
    emit             = 1'b0;
    retry_due        = 1'b0;
    out_kind_nxt     = rrb_pkg::KIND_BUS_REQ;
    out_cmd_nxt      = held_cmd_r;
    out_status_nxt   = held_status_r;
    out_data_nxt     = held_data_r;

    case (rrb_pkg::action_t'(in_action))
      rrb_pkg::ACT_REQUEST: begin
        if (!busy_r) begin
          busy_nxt         = 1'b1;
          held_cmd_nxt     = in_cmd_code;
          held_type_nxt    = in_board_type;
          held_id_nxt      = in_board_id;
          held_status_nxt  = in_status_byte;
          held_data_nxt    = in_data_byte;
          held_station_nxt = in_station;
          retry_count_nxt  = '0;
          tick_count_nxt   = '0;
          emit             = 1'b1;
          out_kind_nxt     = rrb_pkg::KIND_BUS_REQ;
          out_cmd_nxt      = in_cmd_code | flag_mask_r;
          out_status_nxt   = in_status_byte;
          out_data_nxt     = in_data_byte;
        end
      end
      rrb_pkg::ACT_TICK: begin
        if (busy_r) begin
          if (tick_count_r >= timeout_r) begin
            retry_due = 1'b1;
          end else begin
            tick_count_nxt = tick_count_r + 8'd1;
          end
        end
      end
      rrb_pkg::ACT_REPLY: begin
        if (busy_r) begin
          if (in_board_type == held_type_r && in_board_id == held_id_r) begin
            busy_nxt       = 1'b0;
            emit           = 1'b1;
            out_kind_nxt   = rrb_pkg::KIND_CAN_REPLY;
            out_cmd_nxt    = held_cmd_r;
            out_status_nxt = in_status_byte;
            out_data_nxt   = in_data_byte;
          end else begin
            retry_due = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Resend from the held command, or give up with the disconnect reply.
    if (retry_due) begin
      emit = 1'b1;
      if (retry_count_r >= max_retries_r) begin
        busy_nxt       = 1'b0;
        out_kind_nxt   = rrb_pkg::KIND_CAN_REPLY;
        out_cmd_nxt    = held_cmd_r;
        out_status_nxt = disc_status_r;
        out_data_nxt   = '0;
      end else begin
        retry_count_nxt = retry_count_r + 4'd1;
        tick_count_nxt  = '0;
        out_kind_nxt    = rrb_pkg::KIND_BUS_REQ;
        out_cmd_nxt     = held_cmd_r | flag_mask_r;
        out_status_nxt  = held_status_r;
        out_data_nxt    = held_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      held_cmd_r     <= '0;
      held_type_r    <= '0;
      held_id_r      <= '0;
      held_status_r  <= '0;
      held_data_r    <= '0;
      held_station_r <= '0;
      tick_count_r   <= '0;
      retry_count_r  <= '0;
    end else if (in_fire) begin
      busy_r         <= busy_nxt;
      held_cmd_r     <= held_cmd_nxt;
      held_type_r    <= held_type_nxt;
      held_id_r      <= held_id_nxt;
      held_status_r  <= held_status_nxt;
      held_data_r    <= held_data_nxt;
      held_station_r <= held_station_nxt;
      tick_count_r   <= tick_count_nxt;
      retry_count_r  <= retry_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Type, id and station follow the held fields as they stand after this transaction.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r    <= out_kind_nxt;
      out_cmd_r     <= out_cmd_nxt;
      out_type_r    <= held_type_nxt;
      out_id_r      <= held_id_nxt;
      out_status_r  <= out_status_nxt;
      out_data_r    <= out_data_nxt;
      out_station_r <= held_station_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_cmd     = out_cmd_r;
  assign out_type    = out_type_r;
  assign out_id      = out_id_r;
  assign out_status  = out_status_r;
  assign out_data    = out_data_r;
  assign out_station = out_station_r;

`ifndef SYNTHESIS
  a_request_sends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == rrb_pkg::ACT_REQUEST && !busy_r
    |=> out_valid_r && busy_r && out_kind_r == rrb_pkg::KIND_BUS_REQ)
    else $error("idle request did not produce a bus request");

  a_can_reply_idles: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && out_kind_nxt == rrb_pkg::KIND_CAN_REPLY
    |=> !busy_r && tick_count_r == $past(tick_count_r))
    else $error("CAN reply left the bridge busy");

  a_idle_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !busy_r && in_action != rrb_pkg::ACT_REQUEST
    |=> !out_valid_r)
    else $error("event while idle produced a result");

  a_resend_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && out_kind_nxt == rrb_pkg::KIND_BUS_REQ
    |=> tick_count_r == '0 && busy_r)
    else $error("bus request sent without clearing the tick count");
`endif

endmodule
